/* sv/rmts_pkg.sv */
`timescale 1ns / 1ps

package rmts_pkg;

    localparam int TASKS_DEF     = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam int CNT_W   = 4;
    localparam int SLOT_W  = 3;
    localparam int FIELD_W = 16;
    localparam int TICK_W  = 32;

    localparam logic [CNT_W-1:0] TASK_COUNT_RST = 4'd1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

endpackage

/* sv/rate_monotonic_tick_scheduler.sv */
`timescale 1ns / 1ps
// A tick's result goes through the input register and then the result register.
// Throughput: one item per cycle unless i_out_stall holds a tick; release, selection
// and update of all task slots are done in the single stage between those registers.
// Loads produce no result and never wait on the output side.
// Reset (synchronous, active low) clears all task slots and the tick time and sets
// task_count to 1.
module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int TASKS     = TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [SLOT_W-1:0]  i_task_index,
    input  logic [FIELD_W-1:0] i_period,
    input  logic [FIELD_W-1:0] i_burst,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [TICK_W-1:0]  o_tick_time,
    output logic               o_running,
    output logic [SLOT_W-1:0]  o_task_id
);

    localparam int IW = $clog2(TASKS);
    localparam int TW = TIME_BITS;

    logic [CNT_W-1:0] r_task_count;

    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [SLOT_W-1:0]  r_s1_idx;
    logic [FIELD_W-1:0] r_s1_period;
    logic [FIELD_W-1:0] r_s1_burst;

    logic [TW-1:0] r_period [TASKS];
    logic [TW-1:0] r_burst  [TASKS];
    logic [TW-1:0] r_phase  [TASKS];
    logic [TW-1:0] r_work   [TASKS];
    logic [TICK_W-1:0] r_tick;

    logic              r_out_valid;
    logic [TICK_W-1:0] r_out_tick;
    logic              r_out_running;
    logic [SLOT_W-1:0] r_out_id;

    logic              advance;
    logic              s1_go;
    logic              load_ok;
    logic [TASKS-1:0]  in_use;
    logic [TASKS-1:0]  release_now;
    logic [TASKS-1:0]  elig;
    logic [TW-1:0]     n_work_rel [TASKS];
    logic              found;
    logic [IW-1:0]     best;
    logic [TW-1:0]     best_period;

    assign o_cfg_ready = 1'b1;

    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && ((r_s1_op == OP_LOAD) || advance);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign load_ok    = (int'(r_s1_idx) < TASKS);

    always_comb begin
        for (int i = 0; i < TASKS; i++) begin
            in_use[i]      = (i < int'(r_task_count)) && (r_period[i] != '0);
            release_now[i] = in_use[i] && (r_phase[i] == '0);
            n_work_rel[i]  = release_now[i] ? r_burst[i] : r_work[i];
            elig[i]        = in_use[i] && (n_work_rel[i] != '0);
        end
    end

    // smallest period wins; strict compare keeps the lowest index on ties
    always_comb begin
        found       = 1'b0;
        best        = '0;
        best_period = '0;
        for (int i = 0; i < TASKS; i++) begin
            if (elig[i] && (!found || r_period[i] < best_period)) begin
                found       = 1'b1;
                best        = IW'(i);
                best_period = r_period[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_task_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_op     <= t_op'(i_op);
            r_s1_idx    <= i_task_index;
            r_s1_period <= i_period;
            r_s1_burst  <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASKS; i++) begin
                r_period[i] <= '0;
                r_burst[i]  <= '0;
                r_phase[i]  <= '0;
                r_work[i]   <= '0;
            end
            r_tick <= '0;
        end else if (s1_go) begin
            if (r_s1_op == OP_LOAD) begin
                if (load_ok) begin
                    for (int i = 0; i < TASKS; i++) begin
                        if (i == int'(r_s1_idx)) begin
                            r_period[i] <= TW'(r_s1_period);
                            r_burst[i]  <= TW'(r_s1_burst);
                            r_phase[i]  <= '0;
                            r_work[i]   <= '0;
                        end
                    end
                    r_tick <= '0;
                end
            end else begin
                for (int i = 0; i < TASKS; i++) begin
                    if (in_use[i]) begin
                        r_phase[i] <= release_now[i] ? (r_period[i] - 1'b1)
                                                     : (r_phase[i] - 1'b1);
                    end
                    if (found && (i == int'(best))) begin
                        r_work[i] <= n_work_rel[i] - 1'b1;
                    end else begin
                        r_work[i] <= n_work_rel[i];
                    end
                end
                r_tick <= r_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && (r_s1_op == OP_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (r_s1_op == OP_TICK)) begin
            r_out_tick    <= r_tick;
            r_out_running <= found;
            r_out_id      <= found ? SLOT_W'(best) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tick_time = r_out_tick;
    assign o_running   = r_out_running;
    assign o_task_id   = r_out_id;

`ifndef SYNTHESIS
    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_running |-> o_task_id == '0)
        else $error("idle result carries a nonzero task id");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    a_pick_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_op == OP_TICK && found |-> elig[best])
        else $error("selected slot has no work");

    a_load_restarts_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_op == OP_LOAD && load_ok |=> r_tick == '0)
        else $error("tick time not restarted by load");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_op == OP_TICK |=> r_out_tick + 1'b1 == r_tick)
        else $error("tick time did not advance past the reported tick");
`endif

endmodule
